FILE: src/hsvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_pkg: shared types and constants for the HSV to RGB converter
// Fixed-point formats, sector codes and reciprocal constants for the
// divide-by-constant stages.
// ----------------------------------------------------------------------------
package hsvr_pkg;

	// Hue resolution: hue arrives in 1/2^HUE_FRAC_BITS degree units
	localparam int unsigned HUE_FRAC_BITS = 4;
	localparam int unsigned HUE_W         = 13;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned BYTE_MAX      = 255;

	// One 60-degree sector and a full turn, in hue units
	localparam int unsigned SECTOR_W  = 60 << HUE_FRAC_BITS;
	localparam int unsigned FULL_TURN = 360 << HUE_FRAC_BITS;
	localparam int unsigned REM_W     = $clog2(SECTOR_W);
	localparam int unsigned NUM_SECT  = 6;

	// q and t levels: floor(V * num / LEVEL_DEN), num in 0..LEVEL_DEN
	localparam int unsigned LEVEL_DEN = BYTE_MAX * SECTOR_W;
	localparam int unsigned NUM_W     = $clog2(LEVEL_DEN + 1);
	localparam int unsigned XQ_W      = NUM_W + BYTE_W;
	localparam int unsigned QT_RECIP  = (2 ** XQ_W) / LEVEL_DEN;
	localparam int unsigned QT_RCP_W  = $clog2(QT_RECIP + 1);
	localparam int unsigned QT_PROD_W = XQ_W + QT_RCP_W;

	// p level: floor(V * (255 - S) / 255)
	localparam int unsigned XP_W     = 2 * BYTE_W;
	localparam int unsigned P_RECIP  = (2 ** XP_W) / BYTE_MAX;
	localparam int unsigned P_RCP_W  = $clog2(P_RECIP + 1);
	localparam int unsigned P_PROD_W = XP_W + P_RCP_W;

	// Hue sectors, named by the colors they span
	typedef enum logic [2:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

	// Hue split into sector and offset inside the sector
	typedef struct packed {
		sector_t            sector;
		logic [REM_W-1:0]   rem;
	} hue_split_t;

endpackage

FILE: src/hsvr_sector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_sector: hue sector decode
// Forces hue at or past a full turn to zero, then finds the 60-degree sector and
// the offset inside it with parallel compares against the sector bounds.
// ----------------------------------------------------------------------------
module hsvr_sector (
	input  logic [hsvr_pkg::HUE_W-1:0] hue,
	output hsvr_pkg::hue_split_t       split
);

	logic [31:0] hue_c;
	logic [31:0] base;
	logic [2:0]  idx;
	logic [31:0] offs;

	// Clamp, then pick the highest sector bound not above the hue
	always_comb begin
		hue_c = 32'(hue);
		if (hue_c >= 32'(hsvr_pkg::FULL_TURN)) begin
			hue_c = '0;
		end
		idx  = '0;
		base = '0;
		for (int k = 1; k < hsvr_pkg::NUM_SECT; k++) begin
			if (hue_c >= 32'(k * hsvr_pkg::SECTOR_W)) begin
				idx  = 3'(k);
				base = 32'(k * hsvr_pkg::SECTOR_W);
			end
		end
		offs = hue_c - base;
	end

	assign split.sector = hsvr_pkg::sector_t'(idx);
	assign split.rem    = offs[hsvr_pkg::REM_W-1:0];

endmodule

FILE: src/hsv_to_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb: HSV to 8-bit RGB pixel converter
// Five-stage pipeline: sector decode, level numerators, brightness
// products, reciprocal quotient estimate, quotient fixup and channel select.
// ----------------------------------------------------------------------------
// Converts one hue/saturation/brightness word into one RGB word per clock
// while rgb_stall is low. Hue is in 1/16 degree units (values of 360 degrees
// or more count as 0); saturation and brightness are bytes read as value/255.
// Levels are exact fixed-point quotients truncated to a byte. Each word
// passes through five register stages, and its pixel shows on rgb_valid
// once it reaches the last one. Throughput is one word per cycle while
// rgb_stall is low; each of the five pipeline stages holds or advances
// on its own, so bubbles collapse and the input keeps flowing while a
// result waits on rgb_stall until every stage is full.
// ----------------------------------------------------------------------------
module hsv_to_rgb (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           hsv_valid,
	output logic                           hsv_stall,
	input  logic [hsvr_pkg::HUE_W-1:0]     hue,
	input  logic [hsvr_pkg::BYTE_W-1:0]    saturation,
	input  logic [hsvr_pkg::BYTE_W-1:0]    brightness,
	// output channel
	output logic                           rgb_valid,
	input  logic                           rgb_stall,
	output logic [hsvr_pkg::BYTE_W-1:0]    red,
	output logic [hsvr_pkg::BYTE_W-1:0]    green,
	output logic [hsvr_pkg::BYTE_W-1:0]    blue
);

	localparam int unsigned BW  = hsvr_pkg::BYTE_W;
	localparam int unsigned NW  = hsvr_pkg::NUM_W;
	localparam int unsigned XQW = hsvr_pkg::XQ_W;
	localparam int unsigned XPW = hsvr_pkg::XP_W;
	localparam int unsigned QPW = hsvr_pkg::QT_PROD_W;
	localparam int unsigned PPW = hsvr_pkg::P_PROD_W;

	// stage valids and advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en1, en2, en3, en4, en5;

	assign en5       = !valid_s5 || !rgb_stall;
	assign en4       = !valid_s4 || en5;
	assign en3       = !valid_s3 || en4;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign hsv_stall = !en1;
	assign rgb_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= hsv_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
		end
	end

	// ---- stage 1: sector decode
	hsvr_pkg::hue_split_t     split;
	hsvr_pkg::sector_t        sector_s1;
	logic [hsvr_pkg::REM_W-1:0] rem_s1;
	logic [BW-1:0]            sat_s1, bri_s1;

	hsvr_sector u_sector (
		.hue   (hue),
		.split (split)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			sector_s1 <= split.sector;
			rem_s1    <= split.rem;
			sat_s1    <= saturation;
			bri_s1    <= brightness;
		end
	end

	// ---- stage 2: level numerators and p product
	logic [NW-1:0]  sr_q, sr_t;
	logic [XPW-1:0] xp_c;
	logic [NW-1:0]  num_q_s2, num_t_s2;
	logic [XPW-1:0] x_p_s2;
	hsvr_pkg::sector_t sector_s2;
	logic [BW-1:0]  bri_s2;

	always_comb begin
		sr_q = NW'(sat_s1) * NW'(rem_s1);
		sr_t = NW'(sat_s1) * (NW'(hsvr_pkg::SECTOR_W) - NW'(rem_s1));
		xp_c = XPW'(bri_s1) * (XPW'(hsvr_pkg::BYTE_MAX) - XPW'(sat_s1));
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			num_q_s2  <= NW'(hsvr_pkg::LEVEL_DEN) - sr_q;
			num_t_s2  <= NW'(hsvr_pkg::LEVEL_DEN) - sr_t;
			x_p_s2    <= xp_c;
			sector_s2 <= sector_s1;
			bri_s2    <= bri_s1;
		end
	end

	// ---- stage 3: brightness times numerators
	logic [XQW-1:0] x_q_s3, x_t_s3;
	logic [XPW-1:0] x_p_s3;
	hsvr_pkg::sector_t sector_s3;
	logic [BW-1:0]  bri_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			x_q_s3    <= XQW'(bri_s2) * XQW'(num_q_s2);
			x_t_s3    <= XQW'(bri_s2) * XQW'(num_t_s2);
			x_p_s3    <= x_p_s2;
			sector_s3 <= sector_s2;
			bri_s3    <= bri_s2;
		end
	end

	// ---- stage 4: reciprocal quotient estimate (low by at most one)
	logic [QPW-1:0] pr_q, pr_t;
	logic [PPW-1:0] pr_p;
	logic [BW-1:0]  est_q_s4, est_t_s4, est_p_s4;
	logic [XQW-1:0] x_q_s4, x_t_s4;
	logic [XPW-1:0] x_p_s4;
	hsvr_pkg::sector_t sector_s4;
	logic [BW-1:0]  bri_s4;

	always_comb begin
		pr_q = QPW'(x_q_s3) * QPW'(hsvr_pkg::QT_RECIP);
		pr_t = QPW'(x_t_s3) * QPW'(hsvr_pkg::QT_RECIP);
		pr_p = PPW'(x_p_s3) * PPW'(hsvr_pkg::P_RECIP);
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			est_q_s4  <= pr_q[XQW+BW-1:XQW];
			est_t_s4  <= pr_t[XQW+BW-1:XQW];
			est_p_s4  <= pr_p[XPW+BW-1:XPW];
			x_q_s4    <= x_q_s3;
			x_t_s4    <= x_t_s3;
			x_p_s4    <= x_p_s3;
			sector_s4 <= sector_s3;
			bri_s4    <= bri_s3;
		end
	end

	// ---- stage 5: quotient fixup and channel select
	logic [XQW-1:0] r_q, r_t;
	logic [XPW-1:0] r_p;
	logic [BW-1:0]  lv_q, lv_t, lv_p;
	logic [BW-1:0]  red_c, green_c, blue_c;
	logic [BW-1:0]  red_s5, green_s5, blue_s5;

	always_comb begin
		r_q  = x_q_s4 - XQW'(est_q_s4) * XQW'(hsvr_pkg::LEVEL_DEN);
		r_t  = x_t_s4 - XQW'(est_t_s4) * XQW'(hsvr_pkg::LEVEL_DEN);
		r_p  = x_p_s4 - XPW'(est_p_s4) * XPW'(hsvr_pkg::BYTE_MAX);
		lv_q = est_q_s4 + BW'(r_q >= XQW'(hsvr_pkg::LEVEL_DEN));
		lv_t = est_t_s4 + BW'(r_t >= XQW'(hsvr_pkg::LEVEL_DEN));
		lv_p = est_p_s4 + BW'(r_p >= XPW'(hsvr_pkg::BYTE_MAX));
		case (sector_s4)
			hsvr_pkg::SEC_R_Y: begin
				red_c = bri_s4; green_c = lv_t;   blue_c = lv_p;
			end
			hsvr_pkg::SEC_Y_G: begin
				red_c = lv_q;   green_c = bri_s4; blue_c = lv_p;
			end
			hsvr_pkg::SEC_G_C: begin
				red_c = lv_p;   green_c = bri_s4; blue_c = lv_t;
			end
			hsvr_pkg::SEC_C_B: begin
				red_c = lv_p;   green_c = lv_q;   blue_c = bri_s4;
			end
			hsvr_pkg::SEC_B_M: begin
				red_c = lv_t;   green_c = lv_p;   blue_c = bri_s4;
			end
			default: begin
				red_c = bri_s4; green_c = lv_p;   blue_c = lv_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= red_c;
			green_s5 <= green_c;
			blue_s5  <= blue_c;
		end
	end

	assign red   = red_s5;
	assign green = green_s5;
	assign blue  = blue_s5;

	// ---- checks
	// sector offset always lies inside one sector
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (32'(rem_s1) < hsvr_pkg::SECTOR_W))
		else $error("sector offset out of range");

	// reciprocal estimate is never off by more than one
	a_est_q: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (32'(r_q) < 2 * hsvr_pkg::LEVEL_DEN) &&
			(32'(r_t) < 2 * hsvr_pkg::LEVEL_DEN))
		else $error("q/t quotient estimate too low");

	a_est_p: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (32'(r_p) < 2 * hsvr_pkg::BYTE_MAX))
		else $error("p quotient estimate too low");

	// input only stalls when the first stage holds a word that cannot move
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5)
		else $error("input stalled with a free stage");

endmodule
